@@ rtl/kdlr_pkg.sv @@
// Shared types and constants of the key debounce, long-press and repeat unit.
package kdlr_pkg;

   localparam int RAW_WIDTH      = 4;
   localparam int CODE_WIDTH     = 4;
   localparam int FILTER_WIDTH   = 7;
   localparam int COUNT_WIDTH    = 8;
   localparam int TIME_WIDTH     = 16;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [1:0] REG_DEBOUNCE      = 2'd0;
   localparam logic [1:0] REG_HOLD_LIMIT    = 2'd1;
   localparam logic [1:0] REG_REPEAT_PERIOD = 2'd2;

   localparam logic [FILTER_WIDTH-1:0] DEBOUNCE_RESET      = 7'd5;
   localparam logic [TIME_WIDTH-1:0]   HOLD_LIMIT_RESET    = 16'd100;
   localparam logic [TIME_WIDTH-1:0]   REPEAT_PERIOD_RESET = 16'd5;

   localparam logic [7:0] CODE_PRESS   = 8'd1;
   localparam logic [7:0] CODE_RELEASE = 8'd2;
   localparam logic [7:0] CODE_LONG    = 8'd3;

   typedef struct packed {
      logic [FILTER_WIDTH-1:0] debounce_ticks;
      logic [TIME_WIDTH-1:0]   hold_limit;
      logic [TIME_WIDTH-1:0]   repeat_period;
   } kdlr_cfg_type;

   typedef struct packed {
      logic primary;   // press or release code
      logic is_press;
      logic long_ev;   // long or repeat code
   } kdlr_event_type;

endpackage

@@ rtl/kdlr_lane.sv @@
// Per-key debounce, long-press and repeat counters.
module kdlr_lane
   import kdlr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic           down,
   input  kdlr_cfg_type   cfg,
   output kdlr_event_type events
);

   logic [COUNT_WIDTH-1:0] fc_ff, fc_in;
   logic                   pressed_ff, pressed_in;
   logic [TIME_WIDTH-1:0]  hold_ff, hold_in;
   logic [TIME_WIDTH-1:0]  repeat_ff, repeat_in;
   logic [COUNT_WIDTH-1:0] ft_wide;
   logic [COUNT_WIDTH-1:0] ft_twice;
   logic [TIME_WIDTH-1:0]  hold_next;
   logic [TIME_WIDTH-1:0]  rc_next;

   assign ft_wide  = {1'b0, cfg.debounce_ticks};
   assign ft_twice = {cfg.debounce_ticks, 1'b0};
   assign hold_next = hold_ff + 16'd1;
   assign rc_next   = (repeat_ff != 16'hFFFF) ? repeat_ff + 16'd1 : repeat_ff;

   always_comb begin
      fc_in      = fc_ff;
      pressed_in = pressed_ff;
      hold_in    = hold_ff;
      repeat_in  = repeat_ff;
      events     = '0;
      if (down) begin
         if (fc_ff < ft_wide) begin
            fc_in = ft_wide;
         end else if (fc_ff < ft_twice) begin
            fc_in = fc_ff + 8'd1;
         end else begin
            if (!pressed_ff) begin
               pressed_in      = 1'b1;
               events.primary  = 1'b1;
               events.is_press = 1'b1;
            end
            if (cfg.hold_limit != '0) begin
               if (hold_ff < cfg.hold_limit) begin
                  hold_in = hold_next;
                  if (hold_next >= cfg.hold_limit) begin
                     events.long_ev = 1'b1;
                  end
               end else if (rc_next >= cfg.repeat_period) begin
                  repeat_in      = '0;
                  events.long_ev = 1'b1;
               end else begin
                  repeat_in = rc_next;
               end
            end
         end
      end else begin
         if (fc_ff > ft_wide) begin
            fc_in = ft_wide;
         end else if (fc_ff != '0) begin
            fc_in = fc_ff - 8'd1;
         end else if (pressed_ff) begin
            pressed_in     = 1'b0;
            events.primary = 1'b1;
         end
         hold_in   = '0;
         repeat_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff      <= '0;
         pressed_ff <= 1'b0;
         hold_ff    <= '0;
         repeat_ff  <= '0;
      end else if (step) begin
         fc_ff      <= fc_in;
         pressed_ff <= pressed_in;
         hold_ff    <= hold_in;
         repeat_ff  <= repeat_in;
      end
   end

endmodule

@@ rtl/kdlr_merge.sv @@
// Merge of lane events into one ordered result stream with an output register.
module kdlr_merge
   import kdlr_pkg::*;
#(
   parameter int NUM_KEYS = 4
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  kdlr_event_type [NUM_KEYS-1:0] events,
   output logic                          load_ready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [CODE_WIDTH-1:0]         rsp_code,
   output logic                          rsp_last
);

   localparam int NUM_BITS = 2 * NUM_KEYS;
   localparam int KW       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int IW       = KW + 1;

   logic [NUM_BITS-1:0]   pend_ff, pend_in;
   logic [NUM_KEYS-1:0]   press_ff, press_in;
   logic                  valid_ff, valid_in;
   logic [CODE_WIDTH-1:0] code_ff, code_in;
   logic                  last_ff, last_in;
   logic [NUM_BITS-1:0]   new_mask;
   logic [NUM_KEYS-1:0]   new_press;
   logic [NUM_BITS-1:0]   rest;
   logic [IW-1:0]         idx;
   logic [KW-1:0]         key;
   logic [7:0]            offset;
   logic [7:0]            code_wide;
   logic                  have;
   logic                  load_out;
   logic                  pop;

   always_comb begin
      for (int k = 0; k < NUM_KEYS; k++) begin
         new_mask[2*k]   = events[k].primary;
         new_mask[2*k+1] = events[k].long_ev;
         new_press[k]    = events[k].is_press;
      end
   end

   // lowest pending bit goes first: key order, press before long
   always_comb begin
      idx = '0;
      for (int i = NUM_BITS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            idx = IW'(i);
         end
      end
   end

   assign key       = idx[IW-1:1];
   assign offset    = idx[0] ? CODE_LONG : (press_ff[key] ? CODE_PRESS : CODE_RELEASE);
   assign code_wide = 8'(key) * 8'd3 + offset;

   assign rest       = pend_ff & (pend_ff - NUM_BITS'(1));
   assign have       = |pend_ff;
   assign load_out   = !valid_ff || rsp_tready;
   assign pop        = have && load_out;
   assign load_ready = !have || (pop && (rest == '0));

   always_comb begin
      pend_in  = pend_ff;
      press_in = press_ff;
      valid_in = valid_ff;
      code_in  = code_ff;
      last_in  = last_ff;
      if (pop) begin
         pend_in = rest;
      end
      if (load) begin
         pend_in  = new_mask;
         press_in = new_press;
      end
      if (load_out) begin
         valid_in = have;
         code_in  = code_wide[CODE_WIDTH-1:0];
         last_in  = (rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
      press_ff <= press_in;
      code_ff  <= code_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_code   = code_ff;
   assign rsp_last   = last_ff;

endmodule

@@ rtl/key_debounce_long_repeat_unit.sv @@
// State and pending events load at the accepting edge; results pass the output register.
// Throughput: a scan request yields at most NUM_KEYS+1 results, which leave one per cycle
// while rsp_tready is high; the next request is taken as the last result is registered.
// A request without results is taken every cycle while none are pending.
// Reset: synchronous; clears all key counters and pending results, loads default timings.
module key_debounce_long_repeat_unit
   import kdlr_pkg::*;
#(
   parameter int NUM_KEYS = 4
)
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [3:0] raw_keys, [7:4] zero
   // result channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // [3:0] event code, [7:4] zero
   output logic                      rsp_tlast,
   // register port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   kdlr_cfg_type                  cfg_ff, cfg_in;
   kdlr_event_type [NUM_KEYS-1:0] events;
   logic [NUM_KEYS-1:0]           down;
   logic [RAW_WIDTH-1:0]          raw;
   logic                          single;
   logic                          step;
   logic                          load_ready;
   logic                          csr_write;
   logic [CODE_WIDTH-1:0]         rsp_code;

   // ---------------------------------------------------------------
   // Register port: always ready; write on the access phase.
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            REG_DEBOUNCE:      cfg_in.debounce_ticks = csr_pwdata[FILTER_WIDTH-1:0];
            REG_HOLD_LIMIT:    cfg_in.hold_limit     = csr_pwdata[TIME_WIDTH-1:0];
            REG_REPEAT_PERIOD: cfg_in.repeat_period  = csr_pwdata[TIME_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_DEBOUNCE:      csr_prdata = CSR_DATA_WIDTH'(cfg_ff.debounce_ticks);
         REG_HOLD_LIMIT:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.hold_limit);
         REG_REPEAT_PERIOD: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.repeat_period);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.hold_limit     <= HOLD_LIMIT_RESET;
         cfg_ff.repeat_period  <= REPEAT_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------
   // Key qualification: a key is down only when it is the sole raw key
   // down; keys past the raw width always read as up.
   // ---------------------------------------------------------------
   assign raw    = req_tdata[RAW_WIDTH-1:0];
   assign single = (raw != '0) && ((raw & (raw - RAW_WIDTH'(1))) == '0);
   assign step   = req_tvalid && req_tready;

   // ---------------------------------------------------------------
   // One lane per key; all lanes advance together on each accepted request.
   // ---------------------------------------------------------------
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      if (k < RAW_WIDTH) begin : g_wired
         assign down[k] = single && raw[k];
      end else begin : g_unwired
         assign down[k] = 1'b0;
      end

      kdlr_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .step   (step),
         .down   (down[k]),
         .cfg    (cfg_ff),
         .events (events[k])
      );
   end

   // ---------------------------------------------------------------
   // Merge: hold this request's events and drain them in key order while
   // the next request is taken as soon as the last one leaves.
   // ---------------------------------------------------------------
   kdlr_merge #(
      .NUM_KEYS (NUM_KEYS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .events     (events),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_code   (rsp_code),
      .rsp_last   (rsp_tlast)
   );

   assign req_tready = load_ready;
   assign rsp_tdata  = {{(8-CODE_WIDTH){1'b0}}, rsp_code};

endmodule
